[sv/aebt_pkg.sv]
// ----------------------------------------------------------------------------
// aebt_pkg
// Shared types and constants for the envelope / balance / transient tracker:
// command and configuration structs, state codes, reset values and the fixed
// Q0.16 decay factors.
// ----------------------------------------------------------------------------
package aebt_pkg;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // register reset values
    localparam logic [15:0] ATK_COEF_RST = 16'd36045;
    localparam logic [15:0] REL_COEF_RST = 16'd5243;
    localparam logic [15:0] BAL_COEF_RST = 16'd11796;
    localparam logic [7:0]  TR_GAIN_RST  = 8'd18;

    // fixed decay factors, Q0.16
    localparam logic [15:0] DECAY_IDLE_ENV   = 16'd60293;
    localparam logic [15:0] DECAY_IDLE_BAL   = 16'd58982;
    localparam logic [15:0] DECAY_IDLE_TRANS = 16'd51118;
    localparam logic [15:0] DECAY_MONO_BAL   = 16'd53740;
    localparam logic [15:0] DECAY_TRANS      = 16'd47186;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ATK_COEF = 2'd0,
        CFG_REL_COEF = 2'd1,
        CFG_BAL_COEF = 2'd2,
        CFG_TR_GAIN  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] atk_coef;
        logic [15:0] rel_coef;
        logic [15:0] bal_coef;
        logic [7:0]  tr_gain;
    } t_cfg;

    // block classification done by the front end
    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_MONO,
        KIND_STEREO
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] rms;
        logic [15:0] left;
        logic [15:0] right;
    } t_cmd;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_DIV,
        ST_BAL_MUL,
        ST_BAL_UPD,
        ST_TR_MUL,
        ST_TR_DEC,
        ST_TR_UPD,
        ST_OUT
    } t_back_state;

endpackage

[sv/aebt_front.sv]
// ----------------------------------------------------------------------------
// aebt_front
// Input side: takes block analyses, classifies them by channel count and
// pushes one command per transfer into the queue.
// ----------------------------------------------------------------------------
module aebt_front import aebt_pkg::*; (
    input  logic        i_valid,
    input  logic [3:0]  i_channel_count,
    input  logic [15:0] i_rms_level,
    input  logic [15:0] i_left_level,
    input  logic [15:0] i_right_level,
    input  logic        i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_cmd        o_cmd
);

    // hold off the sender while the queue has no room
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // classify by channel count
    always_comb begin
        o_cmd.rms   = i_rms_level;
        o_cmd.left  = i_left_level;
        o_cmd.right = i_right_level;
        case (i_channel_count)
            4'd0:    o_cmd.kind = KIND_IDLE;
            4'd1:    o_cmd.kind = KIND_MONO;
            default: o_cmd.kind = KIND_STEREO;
        endcase
    end

endmodule

[sv/aebt_queue.sv]
// ----------------------------------------------------------------------------
// aebt_queue
// Short command queue between front and back, so each side stalls on its own.
// ----------------------------------------------------------------------------
module aebt_queue import aebt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/aebt_back.sv]
// ----------------------------------------------------------------------------
// aebt_back
// Execution side: a sequencer around one shared 16x16 multiplier and a
// radix-2 restoring divider updates envelope, balance and transient, then
// loads the output register.
// ----------------------------------------------------------------------------
module aebt_back import aebt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_envelope,
    output logic signed [15:0] o_balance,
    output logic [15:0]        o_transient
);

    // round a Q0.16 product half up and drop the fraction
    function automatic logic [15:0] round_q16(input logic [31:0] p);
        logic [31:0] s;
        s = p + 32'd32768;
        return s[31:16];
    endfunction

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    // tracked state
    logic [15:0] r_env, r_env_old, r_bal, r_trans;

    // datapath registers
    logic [31:0] r_prod;
    logic [17:0] r_rem;
    logic [15:0] r_num, r_quo, r_gained;
    logic [3:0]  r_cnt;
    logic        r_neg;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_env, r_out_bal, r_out_trans;

    logic        w_stereo, w_idle, w_out_load;
    logic [15:0] w_mul_a, w_mul_b;

    // envelope difference
    logic [16:0] w_diff;
    logic        w_diff_neg;
    logic [15:0] w_diff_mag, w_env_coef, w_round;
    logic [17:0] w_env_sum;
    logic [15:0] w_env_new;

    // divider operands
    logic [16:0] w_total;
    logic [15:0] w_dmag;
    logic [17:0] w_div_d;
    logic [18:0] w_div_w, w_div_sub;
    logic        w_div_ge;

    // balance
    logic [15:0] w_quo_sat;
    logic [17:0] w_target, w_bal18, w_t, w_t_abs, w_sres, w_bal_sum;
    logic [16:0] w_bal_abs;
    logic        w_t_neg, w_bal_sign;
    logic [15:0] w_bal_new;

    // transient
    logic [15:0] w_rise, w_trans_new;

    assign w_stereo = (r_cmd.kind == KIND_STEREO);
    assign w_idle   = (r_cmd.kind == KIND_IDLE);
    assign w_round  = round_q16(r_prod);

    // envelope terms
    assign w_diff     = {1'b0, r_cmd.rms} - {1'b0, r_env};
    assign w_diff_neg = w_diff[16];
    assign w_diff_mag = w_diff_neg ? (~w_diff[15:0] + 16'd1) : w_diff[15:0];
    assign w_env_coef = (r_cmd.rms > r_env) ? i_cfg.atk_coef : i_cfg.rel_coef;
    assign w_env_sum  = w_diff_neg ? ({2'b00, r_env} - {2'b00, w_round})
                                   : ({2'b00, r_env} + {2'b00, w_round});
    always_comb begin
        if (w_idle) begin
            w_env_new = w_round;
        end else if (w_env_sum[17]) begin
            w_env_new = '0;
        end else if (w_env_sum[16]) begin
            w_env_new = 16'hFFFF;
        end else begin
            w_env_new = w_env_sum[15:0];
        end
    end

    // divider step: (dmag * 65536 + total) / (2 * total)
    assign w_total   = {1'b0, r_cmd.left} + {1'b0, r_cmd.right};
    assign w_dmag    = (r_cmd.right >= r_cmd.left) ? (r_cmd.right - r_cmd.left)
                                                   : (r_cmd.left - r_cmd.right);
    assign w_div_d   = {w_total, 1'b0};
    assign w_div_w   = {r_rem, r_num[15]};
    assign w_div_ge  = (w_div_w >= {1'b0, w_div_d});
    assign w_div_sub = w_div_w - {1'b0, w_div_d};

    // balance target and smoothing terms
    assign w_quo_sat = (r_quo > 16'd32768) ? 16'd32768 : r_quo;
    assign w_target  = r_neg ? (18'd0 - {2'b00, w_quo_sat})
                             : ((w_quo_sat == 16'd32768) ? 18'd32767 : {2'b00, w_quo_sat});
    assign w_bal18   = {{2{r_bal[15]}}, r_bal};
    assign w_t       = w_target - w_bal18;
    assign w_t_neg   = w_t[17];
    assign w_t_abs   = w_t_neg ? (18'd0 - w_t) : w_t;
    assign w_bal_abs = r_bal[15] ? (17'd0 - {r_bal[15], r_bal}) : {1'b0, r_bal};
    assign w_bal_sign = w_stereo ? w_t_neg : r_bal[15];
    assign w_sres    = w_bal_sign ? (18'd0 - {2'b00, w_round}) : {2'b00, w_round};
    assign w_bal_sum = w_stereo ? (w_bal18 + w_sres) : w_sres;
    always_comb begin
        if (w_bal_sum[17] && (w_bal_sum[16:15] != 2'b11)) begin
            w_bal_new = 16'h8000;
        end else if (!w_bal_sum[17] && (w_bal_sum[16:15] != 2'b00)) begin
            w_bal_new = 16'h7FFF;
        end else begin
            w_bal_new = w_bal_sum[15:0];
        end
    end

    // transient terms
    assign w_rise      = (r_env > r_env_old) ? (r_env - r_env_old) : 16'd0;
    assign w_trans_new = (r_gained > w_round) ? r_gained : w_round;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_cmd_valid) n_state = ST_ENV_MUL;
            ST_ENV_MUL: n_state = ST_ENV_UPD;
            ST_ENV_UPD: n_state = (w_stereo && (w_total != '0)) ? ST_DIV : ST_BAL_MUL;
            ST_DIV:     if (r_cnt == 4'd15) n_state = ST_BAL_MUL;
            ST_BAL_MUL: n_state = ST_BAL_UPD;
            ST_BAL_UPD: n_state = ST_TR_MUL;
            ST_TR_MUL:  n_state = ST_TR_DEC;
            ST_TR_DEC:  n_state = ST_TR_UPD;
            ST_TR_UPD:  n_state = ST_OUT;
            ST_OUT:     if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: queue pop, multiplier operands, output load
    always_comb begin
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        unique case (r_state)
            ST_IDLE: o_pop = i_cmd_valid;
            ST_ENV_MUL: begin
                w_mul_a = w_idle ? r_env : w_diff_mag;
                w_mul_b = w_idle ? DECAY_IDLE_ENV : w_env_coef;
            end
            ST_BAL_MUL: begin
                w_mul_a = w_stereo ? w_t_abs[15:0] : w_bal_abs[15:0];
                if (w_stereo) begin
                    w_mul_b = i_cfg.bal_coef;
                end else begin
                    w_mul_b = w_idle ? DECAY_IDLE_BAL : DECAY_MONO_BAL;
                end
            end
            ST_TR_MUL: begin
                w_mul_a = w_rise;
                w_mul_b = {8'd0, i_cfg.tr_gain};
            end
            ST_TR_DEC: begin
                w_mul_a = r_trans;
                w_mul_b = w_idle ? DECAY_IDLE_TRANS : DECAY_TRANS;
            end
            ST_OUT: w_out_load = !r_out_valid || !i_out_stall;
            ST_ENV_UPD, ST_DIV, ST_BAL_UPD, ST_TR_UPD: ;
        endcase
    end

    // control and tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_env       <= '0;
            r_bal       <= '0;
            r_trans     <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_ENV_UPD) begin
                r_env <= w_env_new;
            end
            if (r_state == ST_BAL_UPD) begin
                r_bal <= w_bal_new;
            end
            if (r_state == ST_TR_UPD) begin
                r_trans <= w_trans_new;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            ST_IDLE: r_cmd <= i_cmd;
            ST_ENV_UPD: begin
                r_env_old <= r_env;
                r_rem     <= {1'b0, {1'b0, w_dmag} + {16'd0, w_total[16]}};
                r_num     <= w_total[15:0];
                r_quo     <= '0;
                r_cnt     <= '0;
                r_neg     <= (r_cmd.left > r_cmd.right);
            end
            ST_DIV: begin
                r_rem <= w_div_ge ? w_div_sub[17:0] : w_div_w[17:0];
                r_num <= {r_num[14:0], 1'b0};
                r_quo <= {r_quo[14:0], w_div_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            ST_TR_DEC: r_gained <= (r_prod[31:16] != '0) ? 16'hFFFF : r_prod[15:0];
            ST_OUT: begin
                if (w_out_load) begin
                    r_out_env   <= r_env;
                    r_out_bal   <= r_bal;
                    r_out_trans <= r_trans;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_envelope  = r_out_env;
    assign o_balance   = r_out_bal;
    assign o_transient = r_out_trans;

endmodule

[sv/audio_envelope_balance_transient.sv]
// ----------------------------------------------------------------------------
// audio_envelope_balance_transient
// Attack/release level envelope follower with smoothed stereo balance and a
// transient detector, one result per audio block analysis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one block analysis (channel
//   count, overall, left and right RMS levels). A transfer lands in a short
//   command queue, so new blocks are taken while the back end is busy.
//   Output channel: o_out_valid / i_out_stall carry envelope, balance and
//   transient. The output register holds a result until it is taken; the
//   back end keeps running on the next command up to that point.
//   Timing: the back end handles one block at a time through a shared 16x16
//   multiplier. Stereo blocks with a nonzero level sum also pass through the
//   bit-serial balance divider, which silent and mono blocks skip.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the register chosen
//   by i_cfg_index (attack, release, balance coefficient, transient gain);
//   write only while no block is in flight.
//   Reset: clears envelope, balance and transient state, empties the queue,
//   drops any pending result and restores the default coefficients.
// ----------------------------------------------------------------------------
module audio_envelope_balance_transient import aebt_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wr_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_channel_count,
    input  logic [15:0]        i_rms_level,
    input  logic [15:0]        i_left_level,
    input  logic [15:0]        i_right_level,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_envelope,
    output logic signed [15:0] o_balance,
    output logic [15:0]        o_transient
);

    t_cfg r_cfg;
    t_cmd w_push_cmd, w_head_cmd;
    logic w_push, w_full, w_pop, w_head_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atk_coef <= ATK_COEF_RST;
            r_cfg.rel_coef <= REL_COEF_RST;
            r_cfg.bal_coef <= BAL_COEF_RST;
            r_cfg.tr_gain  <= TR_GAIN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ATK_COEF: r_cfg.atk_coef <= i_cfg_wr_data;
                CFG_REL_COEF: r_cfg.rel_coef <= i_cfg_wr_data;
                CFG_BAL_COEF: r_cfg.bal_coef <= i_cfg_wr_data;
                CFG_TR_GAIN:  r_cfg.tr_gain  <= i_cfg_wr_data[7:0];
            endcase
        end
    end

    // front end: accept and classify
    aebt_front u_front (
        .i_valid         (i_in_valid),
        .i_channel_count (i_channel_count),
        .i_rms_level     (i_rms_level),
        .i_left_level    (i_left_level),
        .i_right_level   (i_right_level),
        .i_full          (w_full),
        .o_stall         (o_in_stall),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    // command queue
    aebt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head_cmd)
    );

    // back end: arithmetic sequencer and output register
    aebt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_envelope  (o_envelope),
        .o_balance   (o_balance),
        .o_transient (o_transient)
    );

endmodule

[sv/aebt_checker.sv]
// ----------------------------------------------------------------------------
// aebt_checker
// Port-level checks for the envelope / balance / transient tracker, bound to
// the top level.
// ----------------------------------------------------------------------------
module aebt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [15:0]        o_envelope,
    input logic signed [15:0] o_balance,
    input logic [15:0]        o_transient
);

    // reset empties the queue and drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or input stall present after reset");

    // a stalled result stays and keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_envelope)
            && $stable(o_balance) && $stable(o_transient))
        else $error("stalled result changed");

    // the queue only fills through an input transfer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall raised without a transfer");

endmodule

bind audio_envelope_balance_transient aebt_checker u_aebt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_envelope  (o_envelope),
    .o_balance   (o_balance),
    .o_transient (o_transient)
);
